// ===== hdl/rmq_pkg.sv =====
package rmq_pkg;

	localparam int IN_W  = 16;
	localparam int MAG_W = 17;
	localparam int QB    = 18;

	typedef enum logic [2:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z,
		BR_NONE
	} branch_t;

	typedef struct packed {
		branch_t                   branch;
		logic                      dneg;
		logic [2:0]                neg;
		logic [2:0][MAG_W-1:0]     mag;
	} side_t;

	function automatic logic [MAG_W-1:0] absv(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

endpackage

// ===== hdl/rmq_front.sv =====
module rmq_front #(
	parameter int F   = 14,
	parameter int TW  = 19,
	parameter int NWE = 30
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [rmq_pkg::IN_W-1:0] r0c0,
	input  logic signed [rmq_pkg::IN_W-1:0] r0c1,
	input  logic signed [rmq_pkg::IN_W-1:0] r0c2,
	input  logic signed [rmq_pkg::IN_W-1:0] r1c0,
	input  logic signed [rmq_pkg::IN_W-1:0] r1c1,
	input  logic signed [rmq_pkg::IN_W-1:0] r1c2,
	input  logic signed [rmq_pkg::IN_W-1:0] r2c0,
	input  logic signed [rmq_pkg::IN_W-1:0] r2c1,
	input  logic signed [rmq_pkg::IN_W-1:0] r2c2,
	output logic [NWE-1:0]                rad_s1,
	output rmq_pkg::side_t                side_s1
);
	localparam int MW = rmq_pkg::MAG_W;
	localparam logic signed [TW-1:0] ONE  = TW'(1) << F;
	localparam logic signed [TW-1:0] HALF = ONE >>> 1;

	logic signed [TW-1:0] e00, e11, e22, tw, tx, ty, tz, tsel;
	logic signed [MW-1:0] d12, d20, d01, s01, s02, s12;
	logic signed [MW-1:0] v0, v1, v2, wco;
	logic                 sneg;
	rmq_pkg::branch_t     br;
	rmq_pkg::side_t       sd;

	always_comb begin
		e00 = TW'(r0c0);
		e11 = TW'(r1c1);
		e22 = TW'(r2c2);
		tw  = ONE + e00 + e11 + e22;
		tx  = ONE + e00 - e11 - e22;
		ty  = ONE - e00 + e11 - e22;
		tz  = ONE - e00 - e11 + e22;
		d12 = MW'(r1c2) - MW'(r2c1);
		d20 = MW'(r2c0) - MW'(r0c2);
		d01 = MW'(r0c1) - MW'(r1c0);
		s01 = MW'(r0c1) + MW'(r1c0);
		s02 = MW'(r2c0) + MW'(r0c2);
		s12 = MW'(r1c2) + MW'(r2c1);
		if (tw >= HALF) begin
			br = rmq_pkg::BR_W; tsel = tw; wco = '0;
			v0 = d12; v1 = d20; v2 = d01;
		end else if (tx >= HALF) begin
			br = rmq_pkg::BR_X; tsel = tx; wco = d12;
			v0 = s01; v1 = s02; v2 = d12;
		end else if (ty >= HALF) begin
			br = rmq_pkg::BR_Y; tsel = ty; wco = d20;
			v0 = s01; v1 = s12; v2 = d20;
		end else if (tz >= HALF) begin
			br = rmq_pkg::BR_Z; tsel = tz; wco = d01;
			v0 = s02; v1 = s12; v2 = d01;
		end else begin
			br = rmq_pkg::BR_NONE; tsel = ONE; wco = '0;
			v0 = '0; v1 = '0; v2 = '0;
		end
		sneg      = wco[MW-1];
		sd.branch = br;
		sd.dneg   = sneg;
		sd.neg    = {v2[MW-1] ^ sneg, v1[MW-1] ^ sneg, v0[MW-1] ^ sneg};
		sd.mag    = {rmq_pkg::absv(v2), rmq_pkg::absv(v1), rmq_pkg::absv(v0)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= NWE'(tsel[TW-2:0]) << (F - 2);
			side_s1 <= sd;
		end
	end

endmodule

// ===== hdl/rmq_sqrt_cell.sv =====
module rmq_sqrt_cell #(
	parameter int RB  = 15,
	parameter int NWE = 30
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RB+1:0]   rem_i,
	input  logic [RB-1:0]   root_i,
	input  logic [NWE-1:0]  rad_i,
	output logic [RB+1:0]   rem_o,
	output logic [RB-1:0]   root_o,
	output logic [NWE-1:0]  rad_o
);
	logic [RB+3:0] trial, sub, nrem;
	logic          ge;

	always_comb begin
		trial = {rem_i, rad_i[NWE-1 -: 2]};
		sub   = (RB+4)'({root_i, 2'b01});
		ge    = trial >= sub;
		nrem  = ge ? trial - sub : trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= nrem[RB+1:0];
			root_o <= {root_i[RB-2:0], ge};
			rad_o  <= rad_i << 2;
		end
	end

endmodule

// ===== hdl/rmq_div_cell.sv =====
module rmq_div_cell #(
	parameter int DW = 17,
	parameter int QB = 18
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DW-1:0]  den_i,
	input  logic [DW:0]    rem_i,
	input  logic [QB-1:0]  low_i,
	input  logic [QB-1:0]  quo_i,
	output logic [DW-1:0]  den_o,
	output logic [DW:0]    rem_o,
	output logic [QB-1:0]  low_o,
	output logic [QB-1:0]  quo_o
);
	logic [DW+1:0] trial, nrem;
	logic          ge;

	always_comb begin
		trial = {rem_i, low_i[QB-1]};
		ge    = trial >= (DW+2)'(den_i);
		nrem  = ge ? trial - (DW+2)'(den_i) : trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_o <= nrem[DW:0];
			low_o <= low_i << 1;
			quo_o <= {quo_i[QB-2:0], ge};
		end
	end

endmodule

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
// Stages: front register, RB square-root cells (15 at FRAC_BITS = 14), QB divide cells, output register.
// Throughput: one request per cycle unless held; every stage is a register, all advancing together.
// The whole chain holds only while a finished result is valid and stalled at the output.
// Reset (arst_n low, asynchronous) clears the stage valid bits and the output valid.
module rotation_matrix_to_quaternion_core #(
	parameter int FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic signed [rmq_pkg::IN_W-1:0]   r0c0,
	input  logic signed [rmq_pkg::IN_W-1:0]   r0c1,
	input  logic signed [rmq_pkg::IN_W-1:0]   r0c2,
	input  logic signed [rmq_pkg::IN_W-1:0]   r1c0,
	input  logic signed [rmq_pkg::IN_W-1:0]   r1c1,
	input  logic signed [rmq_pkg::IN_W-1:0]   r1c2,
	input  logic signed [rmq_pkg::IN_W-1:0]   r2c0,
	input  logic signed [rmq_pkg::IN_W-1:0]   r2c1,
	input  logic signed [rmq_pkg::IN_W-1:0]   r2c2,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [rmq_pkg::IN_W-1:0]   quat_x,
	output logic signed [rmq_pkg::IN_W-1:0]   quat_y,
	output logic signed [rmq_pkg::IN_W-1:0]   quat_z,
	output logic signed [rmq_pkg::IN_W-1:0]   quat_w,
	output logic                              not_orthonormal
);
	localparam int F    = FRAC_BITS;
	localparam int TW   = ((F > 16) ? F : 16) + 3;
	localparam int NW   = TW - 1 + F - 2;
	localparam int NWE  = NW + (NW % 2);
	localparam int RB   = NWE / 2;
	localparam int QB   = rmq_pkg::QB;
	localparam int DW   = RB + 2;
	localparam int NUW  = rmq_pkg::MAG_W + 1 + F;
	localparam int MW   = (QB > RB) ? QB : RB;
	localparam int NST  = 1 + RB + QB;
	localparam logic [rmq_pkg::IN_W-1:0] LIM =
		(F >= 15) ? 16'd32767 : rmq_pkg::IN_W'(1 << F);

	function automatic logic [rmq_pkg::IN_W-1:0] fin(input logic [MW-1:0] m,
		input logic neg);
		logic [rmq_pkg::IN_W-1:0] s;
		s = (m > MW'(LIM)) ? LIM : m[rmq_pkg::IN_W-1:0];
		return neg ? rmq_pkg::IN_W'(-s) : s;
	endfunction

	logic            adv;
	logic [NST-1:0]  vld_q;
	logic            out_valid_q;
	rmq_pkg::side_t  side_q [0:NST-1];

	logic [RB+1:0]   sq_rem  [0:RB];
	logic [RB-1:0]   sq_root [0:RB];
	logic [NWE-1:0]  sq_rad  [0:RB];

	logic [DW-1:0]   dv_den  [0:2][0:QB];
	logic [DW:0]     dv_rem  [0:2][0:QB];
	logic [QB-1:0]   dv_low  [0:2][0:QB];
	logic [QB-1:0]   dv_quo  [0:2][0:QB];

	logic [RB-1:0]   c_root;
	rmq_pkg::side_t  sl;
	logic [MW-1:0]   dm, q0, q1, q2;
	logic [rmq_pkg::IN_W-1:0] ox, oy, oz, ow;

	assign adv       = !(out_valid_q && res_stall);
	assign req_stall = !adv;
	assign res_valid = out_valid_q;

	rmq_front #(.F(F), .TW(TW), .NWE(NWE)) u_front (
		.clk(clk), .en(adv),
		.r0c0(r0c0), .r0c1(r0c1), .r0c2(r0c2),
		.r1c0(r1c0), .r1c1(r1c1), .r1c2(r1c2),
		.r2c0(r2c0), .r2c1(r2c1), .r2c2(r2c2),
		.rad_s1(sq_rad[0]), .side_s1(side_q[0])
	);

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		rmq_sqrt_cell #(.RB(RB), .NWE(NWE)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(sq_rem[k]), .root_i(sq_root[k]), .rad_i(sq_rad[k]),
			.rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]), .rad_o(sq_rad[k+1])
		);
	end

	assign c_root = sq_root[RB];

	for (genvar d = 0; d < 3; d++) begin : g_div
		logic [NUW-1:0] num;
		assign num = (NUW'(side_q[RB].mag[d]) << F) + (NUW'(c_root) << 1);
		assign dv_den[d][0] = {c_root, 2'b00};
		assign dv_rem[d][0] = (DW+1)'(num[NUW-1:QB]);
		assign dv_low[d][0] = num[QB-1:0];
		assign dv_quo[d][0] = '0;
		for (genvar j = 0; j < QB; j++) begin : g_cell
			rmq_div_cell #(.DW(DW), .QB(QB)) u_cell (
				.clk(clk), .en(adv),
				.den_i(dv_den[d][j]), .rem_i(dv_rem[d][j]),
				.low_i(dv_low[d][j]), .quo_i(dv_quo[d][j]),
				.den_o(dv_den[d][j+1]), .rem_o(dv_rem[d][j+1]),
				.low_o(dv_low[d][j+1]), .quo_o(dv_quo[d][j+1])
			);
		end
	end

	for (genvar s = 1; s < NST; s++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_q[s] <= side_q[s-1];
			end
		end
	end

	// dominant root must ride along with the divide cells
	logic [RB-1:0] dom_q [0:QB];
	assign dom_q[0] = c_root;
	for (genvar j = 1; j <= QB; j++) begin : g_dom
		always_ff @(posedge clk) begin
			if (adv) begin
				dom_q[j] <= dom_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NST-2:0], req_valid};
			out_valid_q <= vld_q[NST-1];
		end
	end

	always_comb begin
		sl = side_q[NST-1];
		dm = MW'(dom_q[QB]);
		q0 = MW'(dv_quo[0][QB]);
		q1 = MW'(dv_quo[1][QB]);
		q2 = MW'(dv_quo[2][QB]);
		case (sl.branch)
			rmq_pkg::BR_W: begin
				ow = fin(dm, 1'b0);
				ox = fin(q0, sl.neg[0]);
				oy = fin(q1, sl.neg[1]);
				oz = fin(q2, sl.neg[2]);
			end
			rmq_pkg::BR_X: begin
				ox = fin(dm, sl.dneg);
				oy = fin(q0, sl.neg[0]);
				oz = fin(q1, sl.neg[1]);
				ow = fin(q2, sl.neg[2]);
			end
			rmq_pkg::BR_Y: begin
				oy = fin(dm, sl.dneg);
				ox = fin(q0, sl.neg[0]);
				oz = fin(q1, sl.neg[1]);
				ow = fin(q2, sl.neg[2]);
			end
			rmq_pkg::BR_Z: begin
				oz = fin(dm, sl.dneg);
				ox = fin(q0, sl.neg[0]);
				oy = fin(q1, sl.neg[1]);
				ow = fin(q2, sl.neg[2]);
			end
			default: begin
				ox = '0;
				oy = '0;
				oz = '0;
				ow = LIM;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_x          <= ox;
			quat_y          <= oy;
			quat_z          <= oz;
			quat_w          <= ow;
			not_orthonormal <= (sl.branch == rmq_pkg::BR_NONE);
		end
	end

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_q[0])
		else $error("accepted request did not enter the chain");

	a_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !not_orthonormal |-> !quat_w[rmq_pkg::IN_W-1])
		else $error("negative w on a qualified branch");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && not_orthonormal |-> quat_w == LIM && quat_x == '0)
		else $error("identity fallback wrong");
`endif

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_core;

	localparam int FRAC = 14;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint LIM = (ONE > 32767) ? 32767 : ONE;
	localparam int N_RANDOM = 1800;
	localparam int LATENCY = 35;

	typedef logic signed [15:0] fx_t;

	typedef struct {
		fx_t x, y, z, w;
		logic flag;
	} quat_t;

	typedef struct {
		fx_t m [9];
		logic known;
		quat_t q;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fx_t r0c0 = '0, r0c1 = '0, r0c2 = '0, r1c0 = '0, r1c1 = '0, r1c2 = '0;
	fx_t r2c0 = '0, r2c1 = '0, r2c2 = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	fx_t quat_x, quat_y, quat_z, quat_w;
	logic not_orthonormal;

	quat_t quat_pending [$];
	int errors = 0;
	int n_sent = 0;
	int n_recv = 0;
	int n_branch [4];
	bit hold_go = 1'b0;

	always #5 clk = ~clk;

	rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.r0c0(r0c0), .r0c1(r0c1), .r0c2(r0c2),
		.r1c0(r1c0), .r1c1(r1c1), .r1c2(r1c2),
		.r2c0(r2c0), .r2c1(r2c1), .r2c2(r2c2),
		.res_valid(res_valid), .res_stall(res_stall),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.not_orthonormal(not_orthonormal)
	);

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// v / (4c) in fixed point, nearest, ties away from zero, sign flipped when neg
	function automatic longint scaled_div(longint v, longint unsigned c, bit neg);
		longint unsigned mag;
		longint unsigned den;
		longint r;
		mag = (v < 0) ? -v : v;
		den = c * 4;
		r = longint'(((mag << FRAC) + den / 2) / den);
		if ((v < 0) != neg)
			r = -r;
		return r;
	endfunction

	function automatic fx_t clamp(longint v);
		if (v > LIM)
			v = LIM;
		if (v < -LIM)
			v = -LIM;
		return fx_t'(v);
	endfunction

	function automatic quat_t matrix_to_quat(fx_t m [9]);
		longint a [9];
		longint qx, qy, qz, qw, t, wco;
		longint unsigned c;
		bit neg;
		quat_t q;
		foreach (m[i])
			a[i] = m[i];
		qx = 0; qy = 0; qz = 0; qw = ONE;
		q.flag = 1'b0;
		if ((t = ONE + a[0] + a[4] + a[8]) >= ONE / 2) begin
			c = int_sqrt(longint'(t) << (FRAC - 2));
			qw = c;
			qx = scaled_div(a[5] - a[7], c, 0);
			qy = scaled_div(a[6] - a[2], c, 0);
			qz = scaled_div(a[1] - a[3], c, 0);
		end else if ((t = ONE + a[0] - a[4] - a[8]) >= ONE / 2) begin
			wco = a[5] - a[7];
			neg = wco < 0;
			c = int_sqrt(longint'(t) << (FRAC - 2));
			qx = neg ? -longint'(c) : longint'(c);
			qy = scaled_div(a[1] + a[3], c, neg);
			qz = scaled_div(a[6] + a[2], c, neg);
			qw = scaled_div(wco, c, neg);
		end else if ((t = ONE - a[0] + a[4] - a[8]) >= ONE / 2) begin
			wco = a[6] - a[2];
			neg = wco < 0;
			c = int_sqrt(longint'(t) << (FRAC - 2));
			qy = neg ? -longint'(c) : longint'(c);
			qx = scaled_div(a[1] + a[3], c, neg);
			qz = scaled_div(a[5] + a[7], c, neg);
			qw = scaled_div(wco, c, neg);
		end else if ((t = ONE - a[0] - a[4] + a[8]) >= ONE / 2) begin
			wco = a[1] - a[3];
			neg = wco < 0;
			c = int_sqrt(longint'(t) << (FRAC - 2));
			qz = neg ? -longint'(c) : longint'(c);
			qx = scaled_div(a[6] + a[2], c, neg);
			qy = scaled_div(a[5] + a[7], c, neg);
			qw = scaled_div(wco, c, neg);
		end else begin
			q.flag = 1'b1;
		end
		q.x = clamp(qx);
		q.y = clamp(qy);
		q.z = clamp(qz);
		q.w = clamp(qw);
		return q;
	endfunction

	function automatic int branch_of(fx_t m [9]);
		longint d0, d1, d2;
		d0 = m[0]; d1 = m[4]; d2 = m[8];
		if (ONE + d0 + d1 + d2 >= ONE / 2) return 0;
		if (ONE + d0 - d1 - d2 >= ONE / 2) return 1;
		if (ONE - d0 + d1 - d2 >= ONE / 2) return 2;
		return 3;
	endfunction

	task automatic report(string what, fx_t got, fx_t want);
		$display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, n_recv);
		errors++;
	endtask

	// request side: called right after a rising edge
	task automatic send_matrix(fx_t m [9], quat_t q);
		req_valid <= 1'b1;
		r0c0 <= m[0]; r0c1 <= m[1]; r0c2 <= m[2];
		r1c0 <= m[3]; r1c1 <= m[4]; r1c2 <= m[5];
		r2c0 <= m[6]; r2c1 <= m[7]; r2c2 <= m[8];
		do
			@(posedge clk);
		while (req_stall);
		quat_pending.push_back(q);
		n_branch[branch_of(m)]++;
		n_sent++;
	endtask

	task automatic pause(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic fx_t rand_elem(int mode);
		case (mode)
			0: return fx_t'($urandom_range(32768) - 16384);
			default: return fx_t'($urandom());
		endcase
	endfunction

	function automatic void random_matrix(output fx_t m [9]);
		int perm [3];
		int k, j, mode;
		mode = $urandom_range(9);
		if (mode < 6) begin
			// signed permutation matrix plus noise
			perm = '{0, 1, 2};
			perm.shuffle();
			for (k = 0; k < 3; k++)
				for (j = 0; j < 3; j++)
					m[k*3+j] = fx_t'((perm[k] == j ? ($urandom_range(1) ? 16384 : -16384) : 0)
						+ int'($urandom_range(4000)) - 2000);
		end else begin
			foreach (m[i])
				m[i] = rand_elem(mode == 9);
		end
	endfunction

	// result side
	initial begin
		int phase_len;
		int hold_cnt;
		int level;
		bit hold_done;
		quat_t q;
		phase_len = 0;
		hold_cnt = 0;
		level = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (quat_pending.size() == 0) begin
					$display("unexpected result: x %0d y %0d z %0d w %0d",
						quat_x, quat_y, quat_z, quat_w);
					errors++;
				end else begin
					q = quat_pending.pop_front();
					if (quat_x !== q.x) report("quat_x", quat_x, q.x);
					if (quat_y !== q.y) report("quat_y", quat_y, q.y);
					if (quat_z !== q.z) report("quat_z", quat_z, q.z);
					if (quat_w !== q.w) report("quat_w", quat_w, q.w);
					if (not_orthonormal !== q.flag)
						report("not_orthonormal", fx_t'(not_orthonormal), fx_t'(q.flag));
				end
				n_recv++;
			end
			if (hold_go && !hold_done) begin
				hold_cnt = 400;
				hold_done = 1'b1;
			end
			if (phase_len == 0) begin
				phase_len = $urandom_range(10, 80);
				level = $urandom_range(3);
			end
			phase_len--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= (level == 0) ? 1'b0 : ($urandom_range(9) < level * 2);
			end
		end
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t r;
		fx_t m [9];
		int burst;
		int wait_cnt;

		rows = '{
			'{'{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 1, '{0, 0, 0, 16384, 0}},
			'{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 8192, 0}},
			'{'{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1, '{16384, 0, 0, 0, 0}},
			'{'{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}, 1, '{0, 16384, 0, 0, 0}},
			'{'{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}, 1, '{0, 0, 16384, 0, 0}},
			'{'{16384, 0, 0, 0, -16384, -3000, 0, 3000, -16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{16384, 0, 0, 0, -16384, 3000, 0, -3000, -16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{-16384, 0, -3000, 0, 16384, 0, 3000, 0, -16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{-16384, 0, 3000, 0, 16384, 0, -3000, 0, -16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{-16384, -3000, 0, 3000, -16384, 0, 0, 0, 16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{-16384, 3000, 0, -3000, -16384, 0, 0, 0, 16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}, 0, '{0, 0, 0, 0, 0}},
			'{'{-8192, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
			'{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
				0, '{0, 0, 0, 0, 0}},
			'{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
				0, '{0, 0, 0, 0, 0}},
			'{'{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768},
				0, '{0, 0, 0, 0, 0}},
			'{'{-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768},
				0, '{0, 0, 0, 0, 0}},
			'{'{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767}, 0, '{0, 0, 0, 0, 0}},
			'{'{16384, 16384, 16384, -16384, -16384, -16384, 16384, -16384, 16384},
				0, '{0, 0, 0, 0, 0}},
			'{'{-4096, 1, -1, 1, -4096, -1, 1, 1, -4096}, 0, '{0, 0, 0, 0, 0}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			send_matrix(r.m, r.known ? r.q : matrix_to_quat(r.m));
		end

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3)
				hold_go = 1'b1;
			if (n == N_RANDOM / 3 + 50)
				hold_go = 1'b0;
			if (n == 2 * N_RANDOM / 3) begin
				req_valid <= 1'b0;
				while (quat_pending.size() != 0)
					@(posedge clk);
			end
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(3) != 0)
					pause($urandom_range(1, 6));
			end
			burst--;
			random_matrix(m);
			send_matrix(m, matrix_to_quat(m));
		end
		req_valid <= 1'b0;

		wait_cnt = 0;
		while (quat_pending.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d matrices, checked %0d quaternions", n_sent, n_recv);
		$display("branch counts w/x/y/z: %0d %0d %0d %0d, under random stall and burst traffic",
			n_branch[0], n_branch[1], n_branch[2], n_branch[3]);
		if (errors == 0 && quat_pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, quat_pending.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
